[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the sentence validator.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assert a property on every rising clock edge, skipped while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition never holds at a rising clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[rtl/nsv_pkg.sv]
// Types, character constants and helpers of the sentence validator.
// Depends on nothing; used by the interfaces, nsv_eval and the top level.
`default_nettype none
package nsv_pkg;

  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] DigitBase = 8'd48;
  localparam logic [7:0] UpperA    = 8'h41;
  localparam logic [2:0] PosMax    = 3'd5;
  localparam logic [1:0] StarMax   = 2'd2;
  localparam int unsigned HistDepth = 4;

  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StNoDollar    = 3'd1,
    StNoComma     = 3'd2,
    StManyStars   = 3'd3,
    StBadTerm     = 3'd4,
    StBadChecksum = 3'd5
  } status_e;

  // Sentence state carried from byte to byte; hist[0] is the previous byte.
  typedef struct packed {
    logic                           dollar_ok;
    logic                           comma_seen;
    logic [1:0]                     star_count;
    logic [7:0]                     running_xor;
    logic [HistDepth-1:0][7:0]      hist;
    logic [2:0]                     pos;
  } sent_state_t;

  localparam sent_state_t StateClear = '0;

  // Upper-case hex digit value in bits [3:0]; bit 4 set when not a digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (b >= 8'h30 && b <= 8'h39) begin
        d = b - DigitBase;
        hex_value = {1'b0, d[3:0]};
      end else if (b >= UpperA && b <= 8'h46) begin
        d = b - UpperA + 8'd10;
        hex_value = {1'b0, d[3:0]};
      end else begin
        hex_value = 5'h10;
      end
    end
  endfunction

endpackage
`default_nettype wire

[rtl/nsv_if.sv]
// Valid/ready channels of the sentence validator: byte requests in, status out.
// Depends on nsv_pkg for the status type.
`default_nettype none
interface nsv_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_final;

  modport source (output valid, output char_byte, output is_final, input ready);
  modport sink   (input valid, input char_byte, input is_final, output ready);
endinterface

interface nsv_rsp_if;
  logic            valid;
  logic            ready;
  nsv_pkg::status_e status;
  logic [7:0]      computed_sum;

  modport source (output valid, output status, output computed_sum, input ready);
  modport sink   (input valid, input status, input computed_sum, output ready);
endinterface
`default_nettype wire

[rtl/nsv_eval.sv]
// Per-byte evaluation: next sentence state and the final status of a sentence.
// Depends on nsv_pkg.
`default_nettype none
module nsv_eval (
  input  nsv_pkg::sent_state_t cur_i,
  input  logic [7:0]           char_byte_i,
  input  logic                 is_final_i,
  output nsv_pkg::sent_state_t nxt_o,
  output nsv_pkg::status_e     status_o,
  output logic [7:0]           sum_o
);

  nsv_pkg::sent_state_t upd;
  logic [4:0]           lo_dig;
  logic [4:0]           hi_dig;
  logic                 sum_bad;

  always_comb begin
    upd = cur_i;
    if (cur_i.pos == 3'd0) begin
      upd.dollar_ok = (char_byte_i == nsv_pkg::ChDollar);
    end else if (cur_i.star_count == 2'd0 && char_byte_i != nsv_pkg::ChStar) begin
      upd.running_xor = cur_i.running_xor ^ char_byte_i;
    end
    if (char_byte_i == nsv_pkg::ChComma) begin
      upd.comma_seen = 1'b1;
    end
    if (char_byte_i == nsv_pkg::ChStar && cur_i.star_count < nsv_pkg::StarMax) begin
      upd.star_count = cur_i.star_count + 2'd1;
    end
    // shift history and advance position only for bytes that do not end a sentence
    upd.hist = {cur_i.hist[2:0], char_byte_i};
    if (cur_i.pos < nsv_pkg::PosMax) begin
      upd.pos = cur_i.pos + 3'd1;
    end
  end

  assign lo_dig  = nsv_pkg::hex_value(cur_i.hist[1]);
  assign hi_dig  = nsv_pkg::hex_value(cur_i.hist[2]);
  assign sum_bad = (cur_i.hist[3] != nsv_pkg::ChStar) || lo_dig[4] || hi_dig[4] ||
                   ({hi_dig[3:0], lo_dig[3:0]} != upd.running_xor);

  always_comb begin
    priority if (!upd.dollar_ok) begin
      status_o = nsv_pkg::StNoDollar;
    end else if (!upd.comma_seen) begin
      status_o = nsv_pkg::StNoComma;
    end else if (upd.star_count > 2'd1) begin
      status_o = nsv_pkg::StManyStars;
    end else if (char_byte_i != nsv_pkg::ChLf || cur_i.hist[0] != nsv_pkg::ChCr) begin
      status_o = nsv_pkg::StBadTerm;
    end else if (upd.star_count == 2'd1 && sum_bad) begin
      status_o = nsv_pkg::StBadChecksum;
    end else begin
      status_o = nsv_pkg::StOk;
    end
  end

  assign sum_o = upd.running_xor;
  assign nxt_o = is_final_i ? nsv_pkg::StateClear : upd;

endmodule
`default_nettype wire

[rtl/nmea_sentence_validator_core.sv]
// Top level of the NMEA 0183 sentence validator.
// Depends on nsv_pkg, nsv_if (request and status channels), nsv_eval, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The validator takes one sentence byte per request and answers the byte flagged
// is_final with one status (ok, no dollar, no comma, many stars, bad terminator,
// bad checksum) and the XOR of the bytes after the dollar up to the first star,
// or to the end when there is no star. Bytes that are not final give no answer.
// Throughput is one byte per clock unless a final byte is held: a request lands in an
// input register, and a single pass of compare and XOR logic updates the sentence
// state and, on the final byte, loads the status register, which drives rsp_o.
// Only a final byte that meets a status nobody has taken yet holds in the input
// register, and no new byte is taken while it holds.
// After each final byte the sentence state returns to its reset value.
module nmea_sentence_validator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  nsv_req_if.sink     req_i,
  nsv_rsp_if.source   rsp_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_final_q;

  // sentence state
  nsv_pkg::sent_state_t st_q;
  nsv_pkg::sent_state_t st_d;

  // result register
  logic             out_valid_q;
  nsv_pkg::status_e out_status_q;
  logic [7:0]       out_sum_q;

  nsv_pkg::status_e eval_status;
  logic [7:0]       eval_sum;
  logic             adv;
  logic             in_take;

  // Advance a held byte unless it is final and the result slot is still full.
  assign adv     = in_valid_q && (!in_final_q || !out_valid_q || rsp_o.ready);
  assign in_take = req_i.valid && req_i.ready;

  assign req_i.ready = !in_valid_q || adv;

  nsv_eval u_eval (
    .cur_i       (st_q),
    .char_byte_i (in_byte_q),
    .is_final_i  (in_final_q),
    .nxt_o       (st_d),
    .status_o    (eval_status),
    .sum_o       (eval_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= req_i.char_byte;
      in_final_q <= req_i.is_final;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= nsv_pkg::StateClear;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // Load a status on a final byte; drop the old one once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_final_q) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_final_q) begin
      out_status_q <= eval_status;
      out_sum_q    <= eval_sum;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.computed_sum = out_sum_q;

  `ASSERT_CLK(a_rsp_after_final, clk_i, rst_ni, $rose(out_valid_q) |-> $past(adv && in_final_q), "status raised without a final byte")
  `ASSERT_CLK(a_clear_after_final, clk_i, rst_ni, (adv && in_final_q) |=> (st_q.pos == 3'd0 && st_q.running_xor == 8'h00 && st_q.star_count == 2'd0), "sentence state not cleared after final byte")
  `ASSERT_NEVER(a_star_sat, clk_i, rst_ni, st_q.star_count == 2'd3, "star count past saturation")
  `ASSERT_NEVER(a_pos_sat, clk_i, rst_ni, st_q.pos == 3'd6 || st_q.pos == 3'd7, "byte position past saturation")
  `ASSERT_CLK(a_no_overwrite, clk_i, rst_ni, (out_valid_q && !rsp_o.ready) |=> (out_valid_q && $stable(out_status_q) && $stable(out_sum_q)), "pending status overwritten")

endmodule
`default_nettype wire

[sim/nmea_sentence_validator_core_tb.sv]
// Self-checking testbench of nmea_sentence_validator_core: directed sentences, then random ones.
// Depends on nsv_pkg and on the nsv_req_if / nsv_rsp_if channels of the RTL.
module nmea_sentence_validator_core_tb;

  localparam int RandomItems = 1750;
  localparam int DrainEvery  = 500;
  localparam int CycleLimit  = 250000;
  localparam int TailCycles  = 8;
  localparam int DirRows     = 29;

  // One status as the block should report it.
  typedef struct packed {
    nsv_pkg::status_e st;
    logic [7:0]       sum;
  } verdict_t;

  // Shadow of the sentence state; hist[0] holds the previous byte.
  typedef struct packed {
    logic            dollar;
    logic            comma;
    logic [1:0]      stars;
    logic [7:0]      xsum;
    logic [3:0][7:0] hist;
    logic [2:0]      pos;
  } sentence_t;

  // Directed stimulus: one byte per row; pinned rows carry the status typed in by hand.
  typedef struct {
    logic [7:0]       chr;
    logic             fin;
    logic             pinned;
    nsv_pkg::status_e st;
    logic [7:0]       sum;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  nsv_req_if req_if ();
  nsv_rsp_if rsp_if ();

  nmea_sentence_validator_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  dir_row_t dir_tab [DirRows] = '{
    // a lone zero byte, then a lone 0xFF: no dollar, nothing to XOR
    '{8'h00, 1'b1, 1'b1, nsv_pkg::StNoDollar,    8'h00},
    '{8'hFF, 1'b1, 1'b1, nsv_pkg::StNoDollar,    8'h00},
    // dollar alone: no comma
    '{8'h24, 1'b1, 1'b1, nsv_pkg::StNoComma,     8'h00},
    // "$,<NUL>\r\n": zero byte is plain data, no star, ok
    '{8'h24, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h2C, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h00, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h0D, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h0A, 1'b1, 1'b0, nsv_pkg::StOk,          8'h00},
    // "$,**": two stars
    '{8'h24, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h2C, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h2A, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h2A, 1'b1, 1'b1, nsv_pkg::StManyStars,   8'h2C},
    // "$,\r": short sentence, no LF
    '{8'h24, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h2C, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h0D, 1'b1, 1'b1, nsv_pkg::StBadTerm,     8'h21},
    // "$,*2C\r\n": matching checksum
    '{8'h24, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h2C, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h2A, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h32, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h43, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h0D, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h0A, 1'b1, 1'b0, nsv_pkg::StOk,          8'h00},
    // "$,*2c\r\n": lower-case digit is not a digit
    '{8'h24, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h2C, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h2A, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h32, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h63, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h0D, 1'b0, 1'b0, nsv_pkg::StOk,          8'h00},
    '{8'h0A, 1'b1, 1'b1, nsv_pkg::StBadChecksum, 8'h2C}
  };

  sentence_t snt;
  verdict_t  pending_verdicts [$];
  int        mismatches = 0;
  int        statuses_checked = 0;
  int        bytes_sent;
  int        status_seen [6] = '{default: 0};
  int        cycle_count = 0;
  int        burst_left;
  int        stall_mode = 0;
  int        stall_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Upper-case hex digit to its value; return 0 for anything else.
  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    hex_nibble = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c[3:0] + 4'd9;
    end else begin
      hex_nibble = 1'b0;
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (nsv_pkg::DigitBase + 8'(n))
                           : (nsv_pkg::UpperA + 8'(n) - 8'd10);
  endfunction

  // Advance the shadow state by one accepted byte; return 1 with the status on a final byte.
  function automatic logic scan_byte(input logic [7:0] b, input logic fin, output verdict_t v);
    logic [3:0] lo;
    logic [3:0] hi;
    logic       lo_ok;
    logic       hi_ok;
    v.st = nsv_pkg::StOk;
    v.sum = 8'h00;
    scan_byte = 1'b0;
    if (snt.pos == 3'd0) begin
      snt.dollar = (b == nsv_pkg::ChDollar);
    end else if (snt.stars == 2'd0 && b != nsv_pkg::ChStar) begin
      snt.xsum = snt.xsum ^ b;
    end
    if (b == nsv_pkg::ChComma) snt.comma = 1'b1;
    if (b == nsv_pkg::ChStar && snt.stars != nsv_pkg::StarMax) snt.stars = snt.stars + 2'd1;
    if (fin) begin
      lo_ok = hex_nibble(snt.hist[1], lo);
      hi_ok = hex_nibble(snt.hist[2], hi);
      if (!snt.dollar) begin
        v.st = nsv_pkg::StNoDollar;
      end else if (!snt.comma) begin
        v.st = nsv_pkg::StNoComma;
      end else if (snt.stars == nsv_pkg::StarMax) begin
        v.st = nsv_pkg::StManyStars;
      end else if (b != nsv_pkg::ChLf || snt.hist[0] != nsv_pkg::ChCr) begin
        v.st = nsv_pkg::StBadTerm;
      end else if (snt.stars == 2'd1 &&
                   (snt.hist[3] != nsv_pkg::ChStar || !lo_ok || !hi_ok ||
                    {hi, lo} != snt.xsum)) begin
        v.st = nsv_pkg::StBadChecksum;
      end
      v.sum = snt.xsum;
      snt = '0;
      scan_byte = 1'b1;
    end else begin
      snt.hist = {snt.hist[2:0], b};
      if (snt.pos != nsv_pkg::PosMax) snt.pos = snt.pos + 3'd1;
    end
  endfunction

  // Offer one byte request, hold it until taken, then queue the status it causes.
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic pin,
                           input verdict_t pinned_v);
    int       gap;
    verdict_t v;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // now and then a long burst with no idle cycle at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    req_if.valid     <= 1'b1;
    req_if.char_byte <= b;
    req_if.is_final  <= fin;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    bytes_sent++;
    if (scan_byte(b, fin, v)) begin
      if (pin) v = pinned_v;
      pending_verdicts.push_back(v);
    end
  endtask

  // Drop valid and hold off until every queued status has come back.
  task automatic drain_statuses();
    req_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Build one sentence: mostly well formed with random content, some broken, some noise.
  task automatic send_random_sentence(output int n_bytes);
    logic [7:0] s [$];
    logic [7:0] c;
    logic [7:0] x;
    int         flaw;
    int         n;
    verdict_t   none;
    none = '0;
    x = 8'h00;
    flaw = $urandom_range(0, 99);
    if (flaw < 8) begin
      n = $urandom_range(1, 8);
      repeat (n) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      s.push_back((flaw < 13) ? 8'($urandom_range(0, 255)) : nsv_pkg::ChDollar);
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
        else c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == nsv_pkg::ChStar) c = nsv_pkg::ChComma;
        s.push_back(c);
      end
      // leave the comma out now and then
      if (flaw >= 18 || $urandom_range(0, 1) == 0)
        s.insert($urandom_range(1, s.size()), nsv_pkg::ChComma);
      if (flaw >= 18 && flaw < 23) s.insert($urandom_range(1, s.size()), nsv_pkg::ChStar);
      for (int i = 1; i < s.size(); i++) begin
        if (s[i] == nsv_pkg::ChStar) break;
        x = x ^ s[i];
      end
      if ($urandom_range(0, 2) != 0) begin
        if (flaw >= 23 && flaw < 28) x = x ^ 8'($urandom_range(1, 255));
        s.push_back(nsv_pkg::ChStar);
        s.push_back(hex_char(x[7:4]));
        if (flaw >= 28 && flaw < 33) s.push_back(8'h61 + 8'($urandom_range(0, 5)));
        else s.push_back(hex_char(x[3:0]));
      end
      if (flaw >= 33 && flaw < 38) begin
        case ($urandom_range(0, 3))
          0: s.push_back(nsv_pkg::ChCr);
          1: s.push_back(nsv_pkg::ChLf);
          2: begin
            s.push_back(nsv_pkg::ChLf);
            s.push_back(nsv_pkg::ChCr);
          end
          default: begin
            s.push_back(nsv_pkg::ChCr);
            s.push_back(nsv_pkg::ChLf);
            s.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end else begin
        s.push_back(nsv_pkg::ChCr);
        s.push_back(nsv_pkg::ChLf);
      end
    end
    n_bytes = s.size();
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1, 1'b0, none);
  endtask

  // Receiver: pick a new random stall pattern whenever the current one runs out.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 128);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
      2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_if.ready <= ((cycle_count % 8) >= 5);
    endcase
  end

  // Compare each accepted status with the oldest one queued.
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected status %0d sum %02h", rsp_if.status, rsp_if.computed_sum);
      end else begin
        exp_v = pending_verdicts.pop_front();
        statuses_checked++;
        if (int'(exp_v.st) < 6) status_seen[exp_v.st]++;
        if (rsp_if.status !== exp_v.st || rsp_if.computed_sum !== exp_v.sum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: status #%0d expected %0d/%02h got %0d/%02h", statuses_checked,
                     exp_v.st, exp_v.sum, rsp_if.status, rsp_if.computed_sum);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("ERROR: timeout after %0d cycles, %0d statuses outstanding", cycle_count,
               pending_verdicts.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    verdict_t pin_v;
    int       random_bytes;
    int       next_drain;
    int       n;
    snt = '0;
    bytes_sent = 0;
    burst_left = 0;
    req_if.valid     <= 1'b0;
    req_if.char_byte <= 8'h00;
    req_if.is_final  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      pin_v.st = dir_tab[i].st;
      pin_v.sum = dir_tab[i].sum;
      send_byte(dir_tab[i].chr, dir_tab[i].fin, dir_tab[i].pinned, pin_v);
    end
    drain_statuses();

    random_bytes = 0;
    next_drain = DrainEvery;
    while (random_bytes < RandomItems) begin
      send_random_sentence(n);
      random_bytes += n;
      if (random_bytes >= next_drain) begin
        drain_statuses();
        next_drain += DrainEvery;
      end
    end
    req_if.valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d bytes, checked %0d statuses, %0d mismatches", bytes_sent,
             statuses_checked, mismatches);
    $display("Status mix ok/dollar/comma/stars/term/sum: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
